// ===== design/egcd_pkg.sv =====
// egcd_pkg: shared constants and control/status structs for the extended gcd block
// used by egcd_ctrl and extended_gcd_top; no dependencies
package egcd_pkg;

    // default word width of the coefficients; operands are one bit narrower
    localparam int DATA_WIDTH_DEF = 32;

    // status from the datapath and handshake ports to the sequencer
    typedef struct packed {
        logic in_valid;
        logic out_ready;
        logic cur_zero;
    } egcd_stat_t;

    // strobes from the sequencer to the datapath and handshake ports
    typedef struct packed {
        logic in_ready;
        logic out_valid;
        logic load;
        logic start_div;
        logic div_step;
        logic update;
    } egcd_ctrl_t;

endpackage

// ===== design/egcd_step.sv =====
// egcd_step: one radix-2 step of the shared unit
// restoring division bit plus Horner multiply-accumulate of the quotient bit
// into both coefficient products; no dependencies
module egcd_step #(
    parameter int OPER_WIDTH = 31,
    parameter int DATA_WIDTH = 32
) (
    input  logic [OPER_WIDTH-1:0] rem_i,
    input  logic                  dvd_msb_i,
    input  logic [OPER_WIDTH-1:0] den_i,
    input  logic [DATA_WIDTH-1:0] acc_s_i,
    input  logic [DATA_WIDTH-1:0] acc_t_i,
    input  logic [DATA_WIDTH-1:0] mul_s_i,
    input  logic [DATA_WIDTH-1:0] mul_t_i,
    output logic [OPER_WIDTH-1:0] rem_o,
    output logic [DATA_WIDTH-1:0] acc_s_o,
    output logic [DATA_WIDTH-1:0] acc_t_o
);

    logic [OPER_WIDTH:0] trial;
    logic [OPER_WIDTH:0] den_ext;
    logic [OPER_WIDTH:0] diff;
    logic                qbit;

    // trial subtract of the divisor from the shifted partial remainder
    assign trial   = {rem_i, dvd_msb_i};
    assign den_ext = {1'b0, den_i};
    assign diff    = trial - den_ext;
    assign qbit    = (trial >= den_ext);

    // remainder stays below the divisor, so it fits the operand width
    assign rem_o = qbit ? diff[OPER_WIDTH-1:0] : trial[OPER_WIDTH-1:0];

    // quotient bits arrive msb first: acc = 2*acc + qbit*mul, modulo 2^DATA_WIDTH
    assign acc_s_o = {acc_s_i[DATA_WIDTH-2:0], 1'b0} + (qbit ? mul_s_i : '0);
    assign acc_t_o = {acc_t_i[DATA_WIDTH-2:0], 1'b0} + (qbit ? mul_t_i : '0);

endmodule

// ===== design/egcd_ctrl.sv =====
// egcd_ctrl: sequencer for the extended gcd block
// walks load, remainder check, division steps, update and result hand-off; uses egcd_pkg
module egcd_ctrl #(
    parameter int OPER_WIDTH = egcd_pkg::DATA_WIDTH_DEF - 1
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  egcd_pkg::egcd_stat_t   stat_i,
    output egcd_pkg::egcd_ctrl_t   ctrl_o
);

    localparam int CNT_W = $clog2(OPER_WIDTH);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_UPDATE = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    // next state and strobes
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ctrl_o     = '0;
        case (state_reg)
            ST_IDLE: begin
                ctrl_o.in_ready = 1'b1;
                if (stat_i.in_valid) begin
                    ctrl_o.load = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (stat_i.cur_zero) begin
                    state_next = ST_DONE;
                end else begin
                    ctrl_o.start_div = 1'b1;
                    cnt_next         = CNT_W'(OPER_WIDTH - 1);
                    state_next       = ST_DIV;
                end
            end
            ST_DIV: begin
                ctrl_o.div_step = 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_UPDATE;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_UPDATE: begin
                ctrl_o.update = 1'b1;
                state_next    = ST_CHECK;
            end
            ST_DONE: begin
                ctrl_o.out_valid = 1'b1;
                if (stat_i.out_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and bit counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== design/extended_gcd_top.sv =====
// extended_gcd_top: extended euclidean algorithm, gcd and bezout coefficients
// depends on egcd_pkg, egcd_ctrl and egcd_step
//
//   channel | direction | ports                                       | beat
//   s_      | in        | s_valid s_ready s_operand_a s_operand_b     | one pair of operands
//   m_      | out       | m_valid m_ready m_coeff_s m_coeff_t m_divisor | one result
//
// each euclid step is one remainder check, DATA_WIDTH-1 radix-2 steps of the shared
// divide/multiply-accumulate unit, and one update.
// an item runs k euclid steps before m_valid (at most 45 for 31-bit operands).
// s_ready is high only while idle; the result is held in the coefficient and
// remainder registers until the m_ beat completes. aresetn is synchronous.
module extended_gcd_top #(
    parameter int DATA_WIDTH = egcd_pkg::DATA_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [DATA_WIDTH-2:0]        s_operand_a,
    input  logic [DATA_WIDTH-2:0]        s_operand_b,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [DATA_WIDTH-1:0] m_coeff_s,
    output logic signed [DATA_WIDTH-1:0] m_coeff_t,
    output logic [DATA_WIDTH-2:0]        m_divisor
);

    localparam int OPER_WIDTH = DATA_WIDTH - 1;

    egcd_pkg::egcd_stat_t stat;
    egcd_pkg::egcd_ctrl_t ctrl;

    logic [OPER_WIDTH-1:0] prev_r_reg, prev_r_next;
    logic [OPER_WIDTH-1:0] cur_r_reg,  cur_r_next;
    logic [DATA_WIDTH-1:0] prev_s_reg, prev_s_next;
    logic [DATA_WIDTH-1:0] cur_s_reg,  cur_s_next;
    logic [DATA_WIDTH-1:0] prev_t_reg, prev_t_next;
    logic [DATA_WIDTH-1:0] cur_t_reg,  cur_t_next;
    logic [OPER_WIDTH-1:0] rem_reg,    rem_next;
    logic [OPER_WIDTH-1:0] dvd_reg,    dvd_next;
    logic [DATA_WIDTH-1:0] acc_s_reg,  acc_s_next;
    logic [DATA_WIDTH-1:0] acc_t_reg,  acc_t_next;

    logic [OPER_WIDTH-1:0] step_rem;
    logic [DATA_WIDTH-1:0] step_acc_s;
    logic [DATA_WIDTH-1:0] step_acc_t;

    // status to the sequencer
    assign stat.in_valid  = s_valid;
    assign stat.out_ready = m_ready;
    assign stat.cur_zero  = (cur_r_reg == '0);

    egcd_ctrl #(
        .OPER_WIDTH (OPER_WIDTH)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat_i  (stat),
        .ctrl_o  (ctrl)
    );

    // shared radix-2 divide and multiply-accumulate unit
    egcd_step #(
        .OPER_WIDTH (OPER_WIDTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_step (
        .rem_i     (rem_reg),
        .dvd_msb_i (dvd_reg[OPER_WIDTH-1]),
        .den_i     (cur_r_reg),
        .acc_s_i   (acc_s_reg),
        .acc_t_i   (acc_t_reg),
        .mul_s_i   (cur_s_reg),
        .mul_t_i   (cur_t_reg),
        .rem_o     (step_rem),
        .acc_s_o   (step_acc_s),
        .acc_t_o   (step_acc_t)
    );

    // remainder and coefficient pairs
    always_comb begin
        prev_r_next = prev_r_reg;
        cur_r_next  = cur_r_reg;
        prev_s_next = prev_s_reg;
        cur_s_next  = cur_s_reg;
        prev_t_next = prev_t_reg;
        cur_t_next  = cur_t_reg;
        if (ctrl.load) begin
            prev_r_next = s_operand_a;
            cur_r_next  = s_operand_b;
            prev_s_next = DATA_WIDTH'(1);
            cur_s_next  = '0;
            prev_t_next = '0;
            cur_t_next  = DATA_WIDTH'(1);
        end else if (ctrl.update) begin
            prev_r_next = cur_r_reg;
            cur_r_next  = rem_reg;
            prev_s_next = cur_s_reg;
            cur_s_next  = prev_s_reg - acc_s_reg;
            prev_t_next = cur_t_reg;
            cur_t_next  = prev_t_reg - acc_t_reg;
        end
    end

    // division working registers
    always_comb begin
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        acc_s_next = acc_s_reg;
        acc_t_next = acc_t_reg;
        if (ctrl.start_div) begin
            rem_next   = '0;
            dvd_next   = prev_r_reg;
            acc_s_next = '0;
            acc_t_next = '0;
        end else if (ctrl.div_step) begin
            rem_next   = step_rem;
            dvd_next   = {dvd_reg[OPER_WIDTH-2:0], 1'b0};
            acc_s_next = step_acc_s;
            acc_t_next = step_acc_t;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        prev_r_reg <= prev_r_next;
        cur_r_reg  <= cur_r_next;
        prev_s_reg <= prev_s_next;
        cur_s_reg  <= cur_s_next;
        prev_t_reg <= prev_t_next;
        cur_t_reg  <= cur_t_next;
        rem_reg    <= rem_next;
        dvd_reg    <= dvd_next;
        acc_s_reg  <= acc_s_next;
        acc_t_reg  <= acc_t_next;
    end

    // ports
    assign s_ready   = ctrl.in_ready;
    assign m_valid   = ctrl.out_valid;
    assign m_coeff_s = prev_s_reg;
    assign m_coeff_t = prev_t_reg;
    assign m_divisor = prev_r_reg;

    // checks
    a_ready_valid_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result is pending");

    a_busy_after_in: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (!s_ready && !m_valid))
        else $error("block not busy after an input beat");

    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.div_step |-> (cur_r_reg != '0))
        else $error("division step with zero divisor");

    a_result_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (cur_r_reg == '0))
        else $error("result offered before the remainder reached zero");

    a_out_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready) |=> (!m_valid && s_ready))
        else $error("result beat not followed by idle");

endmodule

// ===== tb/tb.sv =====
// tb: self-checking testbench for extended_gcd_top (gcd and bezout coefficients)
// depends on egcd_pkg and extended_gcd_top; predicts all but the typed rows with its own euclid loop
// directed table first, then about 400 random operand pairs under random flow control
module tb;

    localparam int DW = egcd_pkg::DATA_WIDTH_DEF;
    localparam int OW = DW - 1;
    localparam logic [OW-1:0] OPER_MAX = '1;
    localparam int RANDOM_PAIRS = 400;
    localparam int HOLD_AFTER_RESULTS = 40;
    localparam int HOLD_CYCLES = 3000;

    typedef struct packed {
        logic signed [DW-1:0] coeff_s;
        logic signed [DW-1:0] coeff_t;
        logic [OW-1:0]        divisor;
    } bezout_t;

    typedef struct packed {
        logic [OW-1:0] op_a;
        logic [OW-1:0] op_b;
        logic          typed;
        bezout_t       want;
    } pair_row_t;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_HALF,
        RDY_SPARSE,
        RDY_MOSTLY
    } ready_mode_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [OW-1:0]        s_operand_a;
    logic [OW-1:0]        s_operand_b;
    logic                 m_valid;
    logic                 m_ready;
    logic signed [DW-1:0] m_coeff_s;
    logic signed [DW-1:0] m_coeff_t;
    logic [OW-1:0]        m_divisor;

    bezout_t     expected_results[$];
    bezout_t     head_result;
    int unsigned results_seen;
    int unsigned mismatches;
    int unsigned burst_left;
    logic        long_hold_done;

    extended_gcd_top #(.DATA_WIDTH(DW)) uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operand_a (s_operand_a),
        .s_operand_b (s_operand_b),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_coeff_s   (m_coeff_s),
        .m_coeff_t   (m_coeff_t),
        .m_divisor   (m_divisor)
    );

    // clock
    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // extended euclid with 64-bit wrapping arithmetic, coefficients cut to DW bits
    function automatic bezout_t bezout_of(input logic [OW-1:0] a, input logic [OW-1:0] b);
        logic [63:0] r_prev, r_cur, s_prev, s_cur, t_prev, t_cur;
        logic [63:0] quot, r_next, s_next, t_next;
        bezout_t     res;
        r_prev = 64'(a);
        r_cur  = 64'(b);
        s_prev = 64'd1;
        s_cur  = 64'd0;
        t_prev = 64'd0;
        t_cur  = 64'd1;
        while (r_cur != 64'd0) begin
            quot   = r_prev / r_cur;
            r_next = r_prev - quot * r_cur;
            s_next = s_prev - quot * s_cur;
            t_next = t_prev - quot * t_cur;
            r_prev = r_cur;
            r_cur  = r_next;
            s_prev = s_cur;
            s_cur  = s_next;
            t_prev = t_cur;
            t_cur  = t_next;
        end
        res.coeff_s = s_prev[DW-1:0];
        res.coeff_t = t_prev[DW-1:0];
        res.divisor = r_prev[OW-1:0];
        return res;
    endfunction

    function automatic pair_row_t row_of(input logic [OW-1:0] a, input logic [OW-1:0] b,
                                         input logic typed, input logic signed [DW-1:0] s,
                                         input logic signed [DW-1:0] t,
                                         input logic [OW-1:0] g);
        pair_row_t r;
        r.op_a         = a;
        r.op_b         = b;
        r.typed        = typed;
        r.want.coeff_s = s;
        r.want.coeff_t = t;
        r.want.divisor = g;
        return r;
    endfunction

    // offer one operand pair and hold it until the beat completes
    task automatic send_pair(input logic [OW-1:0] a, input logic [OW-1:0] b,
                             input bezout_t want);
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_operand_a <= a;
        s_operand_b <= b;
        do @(posedge aclk); while (!s_ready);
        expected_results.push_back(want);
    endtask

    // bursts of back-to-back beats, then a gap (now and then a long one)
    task automatic pace_sender();
        int unsigned gap;
        if (burst_left != 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            gap = ($urandom_range(0, 99) < 5) ? $urandom_range(20, 1200)
                                              : $urandom_range(1, 20);
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $error("result with nothing outstanding: s=%0d t=%0d g=%0d",
                       m_coeff_s, m_coeff_t, m_divisor);
                mismatches++;
            end else begin
                head_result = expected_results.pop_front();
                if (m_coeff_s !== head_result.coeff_s) begin
                    $error("coeff_s: expected %0d, got %0d", head_result.coeff_s, m_coeff_s);
                    mismatches++;
                end
                if (m_coeff_t !== head_result.coeff_t) begin
                    $error("coeff_t: expected %0d, got %0d", head_result.coeff_t, m_coeff_t);
                    mismatches++;
                end
                if (m_divisor !== head_result.divisor) begin
                    $error("divisor: expected %0d, got %0d", head_result.divisor, m_divisor);
                    mismatches++;
                end
            end
        end
    end

    // receiver: phases of different stall patterns, plus one long hold-off
    initial begin : receiver
        ready_mode_t mode;
        int unsigned phase_len;
        m_ready        = 1'b0;
        long_hold_done = 1'b0;
        forever begin
            mode      = ready_mode_t'($urandom_range(0, 3));
            phase_len = $urandom_range(16, 256);
            repeat (phase_len) begin
                @(negedge aclk);
                if (!long_hold_done && results_seen >= HOLD_AFTER_RESULTS) begin
                    // block keeps its result and must stall the sender meanwhile
                    long_hold_done = 1'b1;
                    m_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge aclk);
                end
                case (mode)
                    RDY_ALWAYS: m_ready <= 1'b1;
                    RDY_HALF:   m_ready <= ($urandom_range(0, 1) == 0);
                    RDY_SPARSE: m_ready <= ($urandom_range(0, 4) == 0);
                    RDY_MOSTLY: m_ready <= ($urandom_range(0, 4) != 0);
                    default:    m_ready <= 1'b1;
                endcase
            end
        end
    end

    // stimulus
    initial begin : stimulus
        pair_row_t     rows[$];
        bezout_t       want;
        logic [OW-1:0] op_a, op_b, tmp;
        logic [63:0]   fib_lo, fib_hi, fib_nx, factor;
        int unsigned   pick, n;
        s_valid      = 1'b0;
        s_operand_a  = '0;
        s_operand_b  = '0;
        aresetn      = 1'b0;
        results_seen = 0;
        mismatches   = 0;
        burst_left   = 0;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed table: typed rows are plain special cases, the rest use the predictor
        rows.push_back(row_of(31'd0, 31'd0, 1'b1, 32'sd1, 32'sd0, 31'd0));
        rows.push_back(row_of(OPER_MAX, 31'd0, 1'b1, 32'sd1, 32'sd0, OPER_MAX));
        rows.push_back(row_of(31'd0, OPER_MAX, 1'b1, 32'sd0, 32'sd1, OPER_MAX));
        rows.push_back(row_of(31'd0, 31'd1, 1'b1, 32'sd0, 32'sd1, 31'd1));
        rows.push_back(row_of(31'd1, 31'd0, 1'b1, 32'sd1, 32'sd0, 31'd1));
        rows.push_back(row_of(31'd5, 31'd0, 1'b1, 32'sd1, 32'sd0, 31'd5));
        rows.push_back(row_of(31'd0, 31'd12, 1'b1, 32'sd0, 32'sd1, 31'd12));
        rows.push_back(row_of(31'd1, 31'd1, 1'b0, '0, '0, '0));
        rows.push_back(row_of(OPER_MAX, OPER_MAX, 1'b0, '0, '0, '0));
        rows.push_back(row_of(OPER_MAX, 31'd1, 1'b0, '0, '0, '0));
        rows.push_back(row_of(31'd1, OPER_MAX, 1'b0, '0, '0, '0));
        rows.push_back(row_of(OPER_MAX, OPER_MAX - 1, 1'b0, '0, '0, '0));
        // consecutive fibonacci numbers: the longest euclid chain that fits
        rows.push_back(row_of(31'd1836311903, 31'd1134903170, 1'b0, '0, '0, '0));
        rows.push_back(row_of(31'd1134903170, 31'd1836311903, 1'b0, '0, '0, '0));
        rows.push_back(row_of(31'h40000000, 31'h20000000, 1'b0, '0, '0, '0));
        rows.push_back(row_of(OPER_MAX, 31'h40000000, 1'b0, '0, '0, '0));
        rows.push_back(row_of(31'd12, 31'd18, 1'b0, '0, '0, '0));
        rows.push_back(row_of(31'd18, 31'd12, 1'b0, '0, '0, '0));
        rows.push_back(row_of(31'h2AAAAAAA, 31'h55555555, 1'b0, '0, '0, '0));
        rows.push_back(row_of(31'h55555555, 31'h2AAAAAAA, 1'b0, '0, '0, '0));
        rows.push_back(row_of(31'd1000000007, 31'd998244353, 1'b0, '0, '0, '0));
        rows.push_back(row_of(31'd240, 31'd46, 1'b0, '0, '0, '0));

        foreach (rows[i]) begin
            want = rows[i].typed ? rows[i].want : bezout_of(rows[i].op_a, rows[i].op_b);
            send_pair(rows[i].op_a, rows[i].op_b, want);
            pace_sender();
        end

        // random pairs, weighted towards interesting shapes
        repeat (RANDOM_PAIRS) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                op_a = OW'($urandom);
                op_b = OW'($urandom);
            end else if (pick < 52) begin
                op_a = OW'($urandom_range(0, 300));
                op_b = OW'($urandom_range(0, 300));
            end else if (pick < 66) begin
                // shared factor so the gcd is large
                factor = 64'($urandom_range(1, 65535));
                op_a   = OW'(factor * $urandom_range(0, 32'(OPER_MAX) / 32'(factor)));
                op_b   = OW'(factor * $urandom_range(0, 32'(OPER_MAX) / 32'(factor)));
            end else if (pick < 74) begin
                op_a = ($urandom_range(0, 3) == 0) ? '0 : OW'($urandom);
                op_b = '0;
            end else if (pick < 84) begin
                n      = $urandom_range(1, 45);
                fib_lo = 64'd1;
                fib_hi = 64'd1;
                repeat (n - 1) begin
                    fib_nx = fib_lo + fib_hi;
                    fib_lo = fib_hi;
                    fib_hi = fib_nx;
                end
                op_a = OW'(fib_hi);
                op_b = OW'(fib_lo);
            end else if (pick < 92) begin
                // equal operands or an exact multiple
                op_b = OW'($urandom_range(1, 65536));
                op_a = ($urandom_range(0, 1) == 0) ? op_b
                     : OW'(64'(op_b) * $urandom_range(0, 32'(OPER_MAX) / 32'(op_b)));
            end else begin
                case ($urandom_range(0, 4))
                    0:       op_a = '0;
                    1:       op_a = OW'(1);
                    2:       op_a = OPER_MAX;
                    3:       op_a = OPER_MAX - 1;
                    default: op_a = 31'h40000000;
                endcase
                op_b = OW'($urandom);
            end
            if ($urandom_range(0, 1) == 1) begin
                tmp  = op_a;
                op_a = op_b;
                op_b = tmp;
            end
            send_pair(op_a, op_b, bezout_of(op_a, op_b));
            pace_sender();
        end

        @(negedge aclk);
        s_valid <= 1'b0;

        // drain, then watch a little longer for stray results
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (2 * DW + 16) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #200_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
